// ----- src/crc16_pkg.sv -----
`timescale 1ns / 1ps

package crc16_pkg;

  localparam int unsigned CRC_W  = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0] POLY_REFLECTED = 16'h8408;
  localparam logic [CRC_W-1:0] POLY_NORMAL    = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_ALL_ONES   = 16'hFFFF;

  // crc_mode codes
  localparam logic [MODE_W-1:0] MODE_REFLECTED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MSB_FIRST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_X25       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_VALUE = 1'd1;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [MODE_W-1:0] mode_t;

  // lsb-first byte update, eight shift steps
  function automatic crc_t fold_reflected(input crc_t crc, input byte_t data);
    crc_t c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ POLY_REFLECTED) : (c >> 1);
    end
    return c;
  endfunction

  // msb-first byte update
  function automatic crc_t fold_normal(input crc_t crc, input byte_t data);
    crc_t c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ POLY_NORMAL) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- src/crc16_in_if.sv -----
`timescale 1ns / 1ps

interface crc16_in_if;
  logic                 valid;
  logic                 ready;
  crc16_pkg::byte_t     data_byte;
  logic                 first_byte;
  logic                 last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

// ----- src/crc16_out_if.sv -----
`timescale 1ns / 1ps

interface crc16_out_if;
  logic            valid;
  logic            ready;
  crc16_pkg::crc_t crc_value;
  logic            is_final;

  modport source (output valid, output crc_value, output is_final, input ready);
  modport sink (input valid, input crc_value, input is_final, output ready);
endinterface

// ----- src/crc16_ccitt_engine_core.sv -----
`timescale 1ns / 1ps

// path: a request goes from accept through the input register (s1_*), then the result register (out_*)
// throughput: one byte per cycle while out_if.ready does not stall, set by the byte update into crc_r
// the byte update reads crc_r and writes it as the request moves to the result register
// reset: synchronous active-low rst_n clears both stages and the running crc to zero,
// sets crc_mode to 0 and seed_value to 0xffff
module crc16_ccitt_engine_core (
  input  logic                                clk,
  input  logic                                rst_n,
  crc16_in_if.sink                            in_if,
  crc16_out_if.source                         out_if,
  input  logic                                cfg_we,
  input  logic [crc16_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [crc16_pkg::CRC_W-1:0]         cfg_data
);

  logic               s1_valid_r;
  crc16_pkg::byte_t   s1_data_r;
  logic               s1_first_r;
  logic               s1_last_r;

  logic               out_valid_r;
  crc16_pkg::crc_t    out_crc_r;
  logic               out_final_r;

  crc16_pkg::crc_t    crc_r;
  crc16_pkg::mode_t   mode_r;
  crc16_pkg::crc_t    seed_r;

  logic               s1_adv;
  logic               in_take;
  crc16_pkg::crc_t    crc_start;
  crc16_pkg::crc_t    crc_nxt;
  crc16_pkg::crc_t    crc_inv;
  crc16_pkg::crc_t    result_nxt;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || s1_adv;
  assign in_take      = in_if.valid && in_if.ready;

  assign out_if.valid     = out_valid_r;
  assign out_if.crc_value = out_crc_r;
  assign out_if.is_final  = out_final_r;

  always_comb begin
    crc_start = crc_r;
    if (s1_first_r) begin
      crc_start = (mode_r == crc16_pkg::MODE_X25) ? crc16_pkg::CRC_ALL_ONES : seed_r;
    end
    if (mode_r == crc16_pkg::MODE_MSB_FIRST) begin
      crc_nxt = crc16_pkg::fold_normal(crc_start, s1_data_r);
    end else begin
      crc_nxt = crc16_pkg::fold_reflected(crc_start, s1_data_r);
    end
    // x.25 finish: invert then swap bytes, register keeps the raw value
    crc_inv    = ~crc_nxt;
    result_nxt = crc_nxt;
    if (s1_last_r && (mode_r == crc16_pkg::MODE_X25)) begin
      result_nxt = {crc_inv[7:0], crc_inv[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
      mode_r      <= crc16_pkg::MODE_REFLECTED;
      seed_r      <= crc16_pkg::CRC_ALL_ONES;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          crc16_pkg::CFG_CRC_MODE:   mode_r <= cfg_data[crc16_pkg::MODE_W-1:0];
          crc16_pkg::CFG_SEED_VALUE: seed_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        crc_r       <= crc_nxt;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r  <= in_if.data_byte;
      s1_first_r <= in_if.first_byte;
      s1_last_r  <= in_if.last_byte;
    end
    if (s1_adv) begin
      out_crc_r   <= result_nxt;
      out_final_r <= s1_last_r;
    end
  end

endmodule

// ----- verif/crc16_ccitt_engine_core_tb.sv -----
`timescale 1ns / 1ps

module crc16_ccitt_engine_core_tb;
  import crc16_pkg::*;

  class crc_scoreboard;
    typedef struct packed {
      crc_t crc;
      logic fin;
    } crc_result_t;

    mode_t       mode;
    crc_t        seed;
    crc_t        running_crc;
    crc_result_t expected_crcs[$];
    int          errors;

    function new();
      mode        = MODE_REFLECTED;
      seed        = CRC_ALL_ONES;
      running_crc = '0;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, crc_t data);
      if (idx == CFG_CRC_MODE) begin
        mode = data[MODE_W-1:0];
      end else begin
        seed = data;
      end
    endfunction

    // one bit per step, feedback taken from the incoming bit
    function crc_t shift_lsb_first(crc_t c, byte_t b);
      crc_t r;
      logic fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r  = r >> 1;
        if (fb) r ^= POLY_REFLECTED;
      end
      return r;
    endfunction

    function crc_t shift_msb_first(crc_t c, byte_t b);
      crc_t r;
      logic fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[15] ^ b[7-i];
        r  = r << 1;
        if (fb) r ^= POLY_NORMAL;
      end
      return r;
    endfunction

    function void note_request(byte_t b, logic first, logic last);
      crc_t        c;
      crc_t        inv;
      crc_result_t res;
      c = running_crc;
      if (first) c = (mode == MODE_X25) ? CRC_ALL_ONES : seed;
      // mode 3 falls back to the reflected update
      if (mode == MODE_MSB_FIRST) c = shift_msb_first(c, b);
      else c = shift_lsb_first(c, b);
      running_crc = c;
      res.crc = c;
      res.fin = last;
      if (last && mode == MODE_X25) begin
        inv     = ~c;
        res.crc = {inv[7:0], inv[15:8]};
      end
      expected_crcs.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t crc16 check: %s", $time, msg);
      errors++;
    endtask

    task check_result(crc_t crc, logic fin);
      crc_result_t want;
      if (expected_crcs.size() == 0) begin
        report($sformatf("result %h final %0b with nothing expected", crc, fin));
      end else begin
        want = expected_crcs.pop_front();
        if (crc !== want.crc)
          report($sformatf("crc_value %h, expected %h", crc, want.crc));
        if (fin !== want.fin)
          report($sformatf("is_final %0b, expected %0b", fin, want.fin));
      end
    endtask

    task check_leftovers();
      if (expected_crcs.size() != 0)
        report($sformatf("%0d results never arrived", expected_crcs.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CRC_W-1:0]     cfg_data;

  crc16_in_if  in_ch ();
  crc16_out_if out_ch ();

  crc_scoreboard sb = new();

  bit tx_steady;
  bit rx_steady;
  bit hold_start;
  int hold_len;
  int bytes_sent;

  always #2 clk = ~clk;

  crc16_ccitt_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_request(in_ch.data_byte, in_ch.first_byte, in_ch.last_byte);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.crc_value, out_ch.is_final);
  end

  // result side: random stalls, steady stretches and a long hold-off
  initial begin : result_ready
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_left  = hold_len;
        hold_start = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("crc16_ccitt_engine_core_tb: errors");
    $finish;
  end

  task automatic send_byte(byte_t b, logic first, logic last);
    if (!tx_steady && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= first;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // stop offering requests and wait until every result is back
  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_crcs.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, crc_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
  endtask

  task automatic set_mode(mode_t m);
    // upper data bits are don't-care for the mode register
    write_reg(CFG_CRC_MODE, {14'($urandom), m});
  endtask

  task automatic send_message(int len, bit noisy);
    for (int i = 0; i < len; i++) begin
      if (noisy)
        send_byte(byte_t'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_byte(byte_t'($urandom), i == 0, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int    phase;
    int    phase_items;
    int    len;
    crc_t  seed;
    tx_steady  = 1'b0;
    rx_steady  = 1'b0;
    hold_start = 1'b0;
    hold_len   = 0;
    bytes_sent = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= '0;
    in_ch.first_byte <= 1'b0;
    in_ch.last_byte  <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_CRC_MODE;
    cfg_data         <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: reflected, seed all ones, running crc zero
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h31, 1'b1, 1'b0);
    send_byte(8'h32, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    drain();
    set_mode(MODE_MSB_FIRST);
    write_reg(CFG_SEED_VALUE, 16'h0000);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);
    drain();
    // x25 ignores the seed register
    set_mode(MODE_X25);
    write_reg(CFG_SEED_VALUE, 16'h1234);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h02, 1'b0, 1'b1);
    send_byte(8'h03, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    drain();
    set_mode(2'd3);
    write_reg(CFG_SEED_VALUE, 16'hFFFF);
    send_byte(8'h55, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b1);
    // mode switched in the middle of one message
    send_byte(8'h12, 1'b1, 1'b0);
    drain();
    set_mode(MODE_MSB_FIRST);
    send_byte(8'h34, 1'b0, 1'b0);
    drain();
    set_mode(MODE_X25);
    send_byte(8'h56, 1'b0, 1'b1);
    drain();

    phase = 0;
    while (bytes_sent < 1000) begin
      set_mode(mode_t'($urandom_range(3)));
      case ($urandom_range(3))
        0: seed = 16'h0000;
        1: seed = 16'hFFFF;
        default: seed = crc_t'($urandom);
      endcase
      if (phase < 2 || $urandom_range(3) != 0) write_reg(CFG_SEED_VALUE, seed);
      tx_steady = (phase == 2);
      rx_steady = (phase == 2);
      if (phase == 4) begin
        tx_steady  = 1'b1;
        hold_len   = 80;
        hold_start = 1'b1;
      end
      phase_items = 0;
      while (phase_items < 60 + $urandom_range(60)) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_message(len, $urandom_range(9) == 0);
        phase_items += len;
      end
      drain();
      phase++;
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("crc16_ccitt_engine_core_tb: clean");
    end else begin
      $display("crc16_ccitt_engine_core_tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/crc16_pkg.sv
src/crc16_in_if.sv
src/crc16_out_if.sv
src/crc16_ccitt_engine_core.sv
verif/crc16_ccitt_engine_core_tb.sv
